### hw/rtl/fkcr_pkg.sv
// ----------------------------------------------------------------------------
// fkcr_pkg
// Shared types, constants and tables of the cell rate pipeline.
// ----------------------------------------------------------------------------
package fkcr_pkg;

  localparam int PIPE_DEPTH = 8;

  localparam logic [2:0] REG_FAST_THR  = 3'd0;
  localparam logic [2:0] REG_GATE_THR  = 3'd1;
  localparam logic [2:0] REG_SLOW_THR  = 3'd2;
  localparam logic [2:0] REG_SLOW_K    = 3'd3;
  localparam logic [2:0] REG_FAST_RATE = 3'd4;
  localparam logic [2:0] REG_OPEN_RATE = 3'd5;
  localparam logic [2:0] REG_REPOL     = 3'd6;
  localparam logic [2:0] REG_SI_RATE   = 3'd7;

  localparam logic [17:0] GV_PLUS   = 18'd131236;
  localparam logic [17:0] GV1_MINUS = 18'd106998;
  localparam logic [17:0] GV2_MINUS = 18'd3355;
  localparam logic [17:0] GW_PLUS   = 18'd1205;
  localparam logic [17:0] GW_MINUS  = 18'd25575;

  typedef struct packed {
    logic [15:0] fast_thr;
    logic [15:0] gate_thr;
    logic [15:0] slow_thr;
    logic [15:0] slow_k;
    logic [17:0] fast_rate;
    logic [17:0] open_rate;
    logic [17:0] repol_rate;
    logic [17:0] si_rate;
  } cfg_t;

  function automatic logic [16:0] tanh_tab(input logic [4:0] i);
    case (i)
      5'd0: tanh_tab = 17'd0;      5'd1: tanh_tab = 17'd16051;
      5'd2: tanh_tab = 17'd30285;  5'd3: tanh_tab = 17'd41625;
      5'd4: tanh_tab = 17'd49912;  5'd5: tanh_tab = 17'd55593;
      5'd6: tanh_tab = 17'd59320;  5'd7: tanh_tab = 17'd61694;
      5'd8: tanh_tab = 17'd63179;  5'd9: tanh_tab = 17'd64096;
      5'd10: tanh_tab = 17'd64659; 5'd11: tanh_tab = 17'd65003;
      5'd12: tanh_tab = 17'd65212; 5'd13: tanh_tab = 17'd65339;
      5'd14: tanh_tab = 17'd65417; 5'd15: tanh_tab = 17'd65464;
      5'd16: tanh_tab = 17'd65492; 5'd17: tanh_tab = 17'd65509;
      5'd18: tanh_tab = 17'd65520; 5'd19: tanh_tab = 17'd65526;
      5'd20: tanh_tab = 17'd65530; 5'd21: tanh_tab = 17'd65532;
      5'd22: tanh_tab = 17'd65534; 5'd23: tanh_tab = 17'd65535;
      5'd24: tanh_tab = 17'd65535;
      default: tanh_tab = 17'd65536;
    endcase
  endfunction

endpackage

### hw/rtl/fkcr_regs.sv
// ----------------------------------------------------------------------------
// fkcr_regs
// Configuration register file.
// ----------------------------------------------------------------------------
module fkcr_regs (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [17:0]  cfg_data,
  output fkcr_pkg::cfg_t cfg
);
  import fkcr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_thr   <= 16'd8520;
      cfg.gate_thr   <= 16'd2621;
      cfg.slow_thr   <= 16'd56426;
      cfg.slow_k     <= 16'd2560;
      cfg.fast_rate  <= 18'd114688;
      cfg.open_rate  <= 18'd5243;
      cfg.repol_rate <= 18'd1937;
      cfg.si_rate    <= 18'd2260;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FAST_THR:  cfg.fast_thr   <= cfg_data[15:0];
        REG_GATE_THR:  cfg.gate_thr   <= cfg_data[15:0];
        REG_SLOW_THR:  cfg.slow_thr   <= cfg_data[15:0];
        REG_SLOW_K:    cfg.slow_k     <= cfg_data[15:0];
        REG_FAST_RATE: cfg.fast_rate  <= cfg_data;
        REG_OPEN_RATE: cfg.open_rate  <= cfg_data;
        REG_REPOL:     cfg.repol_rate <= cfg_data;
        REG_SI_RATE:   cfg.si_rate    <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

### hw/rtl/fenton_karma_cell_rates_core.sv
// ----------------------------------------------------------------------------
// fenton_karma_cell_rates_core
// Fenton-Karma three-variable cell rate pipeline, one cell per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// One cell is accepted every cycle while the output is not stalled. The
// pipeline has eight register stages: the voltage normalization takes two,
// the fast, slow-outward and slow-inward currents with the tanh
// interpolation take four, and the scaling back to mV per ms with saturation
// takes two. A stall at the output freezes all stages together; no beat is
// lost or repeated.
module fenton_karma_cell_rates_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  membrane_mv,
  input  logic [15:0]         gate_v,
  input  logic [15:0]         gate_w,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  dvm_dt,
  output logic signed [23:0]  gate_v_rate,
  output logic signed [23:0]  gate_w_rate,
  output logic signed [18:0]  gate_v_decay,
  output logic [18:0]         gate_v_drive,
  output logic signed [18:0]  gate_w_decay,
  output logic [18:0]         gate_w_drive
);
  import fkcr_pkg::*;

  cfg_t cfg;
  logic cfg_hit;
  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && (cfg_index[31:3] == 29'd0);

  fkcr_regs u_regs (
    .clk(clk), .rst(rst), .cfg_valid(cfg_hit), .cfg_index(cfg_index[2:0]),
    .cfg_data(cfg_data[17:0]), .cfg(cfg)
  );

  logic [PIPE_DEPTH-1:0] vld;
  logic adv;
  assign adv = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[PIPE_DEPTH-2:0], in_valid};
  end

  // stage 1: numerator, biased to stay positive
  logic [28:0] s1_num;
  logic [15:0] s1_gv, s1_gw;
  // stage 2: u (floor divide by 1714 via reciprocal, bias removed)
  logic signed [19:0] s2_u;
  logic [15:0] s2_gv, s2_gw;
  // stage 3
  logic signed [19:0] s3_u;
  logic s3_ge, s3_le, s3_gvt;
  logic signed [36:0] s3_pp;
  logic signed [37:0] s3_x;
  logic [15:0] s3_gv, s3_gw;
  // stage 4
  logic s4_ge, s4_le, s4_gvt;
  logic signed [20:0] s4_p;
  logic [16:0] s4_t;
  logic s4_neg;
  logic [15:0] s4_gv, s4_gw;
  logic signed [37:0] s4_jso;
  // stage 5
  logic s5_ge, s5_le, s5_gvt;
  logic signed [37:0] s5_vf;
  logic [17:0] s5_onep;
  logic [15:0] s5_gv, s5_gw;
  logic signed [37:0] s5_jso;
  logic [33:0] s5_sw;
  // stage 6
  logic s6_le, s6_gvt;
  logic signed [63:0] s6_jfi, s6_jsi, s6_jso;
  logic [15:0] s6_gv, s6_gw;
  // stage 7: sum scaled by 2^-25, clamped just past the 24-bit output range
  logic s7_le, s7_gvt;
  logic signed [27:0] s7_q;
  logic [15:0] s7_gv, s7_gw;

  function automatic logic signed [63:0] rshr(input logic signed [63:0] n,
                                              input int sh);
    rshr = (n + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // stage 1 comb: 5120*(mv+21504) + 857 + 1714*33648
  logic signed [31:0] c1_num;
  assign c1_num = 32'(membrane_mv) * 32'sd5120 + 32'sd167774009;

  // stage 2 comb: exact floor(n/1714) for n < 2^29
  logic [63:0] c2_p;
  logic signed [19:0] c2_u;
  always_comb begin
    c2_p = {35'd0, s1_num} * 64'd641488698;
    c2_u = signed'(c2_p[59:40]) - 20'sd33648;
  end

  // stage 4 comb: tanh interpolation
  logic [37:0] c4_ax;
  logic [15:0] c4_idx;
  logic [21:0] c4_fr;
  logic [16:0] c4_t0, c4_t1;
  logic signed [63:0] c4_d;
  always_comb begin
    c4_ax = s3_x[37] ? 38'(-s3_x) : 38'(s3_x);
    c4_idx = c4_ax[37:22];
    c4_fr = c4_ax[21:0];
    c4_t0 = tanh_tab(c4_idx[4:0]);
    c4_t1 = tanh_tab(5'(c4_idx[4:0] + 5'd1));
    c4_d = rshr(64'(signed'({1'b0, c4_t1}) - signed'({1'b0, c4_t0})) *
                64'(signed'({1'b0, c4_fr})), 22);
  end

  logic signed [63:0] c6_jfi, c6_jsi;
  always_comb begin
    c6_jfi = -rshr(s5_vf * 64'(signed'({1'b0, s5_gv})), 15);
    c6_jsi = -rshr(64'(s5_sw) * 64'(s5_onep), 16);
  end

  // stage 7 comb: floor((-2*857*sum + 10*2^24) / 2^25), then clamp
  logic signed [63:0] c7_sum, c7_n, c7_q;
  logic signed [27:0] c7_qc;
  always_comb begin
    c7_sum = s6_jfi + s6_jso + s6_jsi;
    c7_n = ((-c7_sum * 64'sd857) <<< 1) + 64'sd167772160;
    c7_q = c7_n >>> 25;
    if (c7_q > 64'sd83886089) c7_qc = 28'sd83886089;
    else if (c7_q < -64'sd83886090) c7_qc = -28'sd83886090;
    else c7_qc = 28'(c7_q);
  end

  // output comb: floor(q/10), biased positive for an exact reciprocal
  logic [27:0] c8_qb;
  logic [63:0] c8_p;
  logic signed [63:0] c8_dv;
  always_comb begin
    c8_qb = 28'(s7_q + 28'sd83886090);
    c8_p = {36'd0, c8_qb} * 64'd429496730;
    c8_dv = 64'(c8_p[63:32]) - 64'sd8388609;
  end

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) sat24 = 24'sh7FFFFF;
    else if (v < -64'sd8388608) sat24 = 24'sh800000;
    else sat24 = 24'(v);
  endfunction

  logic signed [18:0] c8_av, c8_aw;
  logic [18:0] c8_bv, c8_bw;
  logic [17:0] c8_vm;
  always_comb begin
    c8_vm = s7_gvt ? GV1_MINUS : GV2_MINUS;
    c8_av = s7_le ? -19'(c8_vm) : -19'(GV_PLUS);
    c8_bv = s7_le ? 19'(c8_vm) : 19'd0;
    c8_aw = s7_le ? -19'(GW_MINUS) : -19'(GW_PLUS);
    c8_bw = s7_le ? 19'(GW_MINUS) : 19'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num <= c1_num[28:0]; s1_gv <= gate_v; s1_gw <= gate_w;

      s2_u <= c2_u; s2_gv <= s1_gv; s2_gw <= s1_gw;

      s3_u <= s2_u;
      s3_ge <= s2_u >= signed'({4'd0, cfg.fast_thr});
      s3_le <= s2_u <= signed'({4'd0, cfg.fast_thr});
      s3_gvt <= s2_u >= signed'({4'd0, cfg.gate_thr});
      s3_pp <= 37'((21'sd65536 - 21'(s2_u)) * (21'(s2_u) - signed'({5'd0, cfg.fast_thr})));
      s3_x <= 38'(signed'({1'b0, cfg.slow_k}) * (21'(s2_u) - signed'({5'd0, cfg.slow_thr})));
      s3_gv <= s2_gv; s3_gw <= s2_gw;

      s4_ge <= s3_ge; s4_le <= s3_le; s4_gvt <= s3_gvt;
      s4_p <= 21'(rshr(64'(s3_pp), 16));
      s4_t <= (c4_idx >= 16'd24) ? 17'd65536 : 17'(64'(c4_t0) + c4_d);
      s4_neg <= s3_x[37];
      s4_gv <= s3_gv; s4_gw <= s3_gw;
      s4_jso <= s3_le ? 38'(s3_u * signed'({1'b0, cfg.open_rate}))
                      : 38'({cfg.repol_rate, 16'd0});

      s5_ge <= s4_ge; s5_le <= s4_le; s5_gvt <= s4_gvt;
      s5_vf <= 38'(s4_p * signed'({1'b0, cfg.fast_rate}));
      s5_onep <= s4_neg ? 18'd65536 - 18'(s4_t) : 18'd65536 + 18'(s4_t);
      s5_gv <= s4_gv; s5_gw <= s4_gw; s5_jso <= s4_jso;
      s5_sw <= 34'({cfg.si_rate} * s4_gw);

      s6_le <= s5_le; s6_gvt <= s5_gvt;
      s6_jfi <= s5_ge ? c6_jfi : 64'sd0;
      s6_jsi <= c6_jsi;
      s6_jso <= 64'(s5_jso);
      s6_gv <= s5_gv; s6_gw <= s5_gw;

      s7_le <= s6_le; s7_gvt <= s6_gvt;
      s7_q <= c7_qc;
      s7_gv <= s6_gv; s7_gw <= s6_gw;

      dvm_dt <= sat24(c8_dv);
      gate_v_rate <= sat24(rshr(64'(c8_av) * 64'(signed'({1'b0, s7_gv})), 15) + 64'(c8_bv));
      gate_w_rate <= sat24(rshr(64'(c8_aw) * 64'(signed'({1'b0, s7_gw})), 15) + 64'(c8_bw));
      gate_v_decay <= c8_av; gate_v_drive <= c8_bv;
      gate_w_decay <= c8_aw; gate_w_drive <= c8_bw;
    end
  end
endmodule

### dv/tb_fenton_karma_cell_rates_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fenton_karma_cell_rates_core
// Streams cells through the rate pipeline under random input gaps and output
// stalls, predicts every result in fixed point and compares field by field.
// ----------------------------------------------------------------------------
module tb_fenton_karma_cell_rates_core;
  import fkcr_pkg::*;

  localparam int LATENCY = 8;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [23:0] dvm;
    logic [23:0] vrate;
    logic [23:0] wrate;
    logic [18:0] vdecay;
    logic [18:0] vdrive;
    logic [18:0] wdecay;
    logic [18:0] wdrive;
  } rates_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] membrane_mv = '0;
  logic [15:0] gate_v = '0;
  logic [15:0] gate_w = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] dvm_dt, gate_v_rate, gate_w_rate;
  logic signed [18:0] gate_v_decay, gate_w_decay;
  logic [18:0] gate_v_drive, gate_w_drive;

  cfg_t cell_cfg;
  rates_t rates_q[$];
  int errors = 0;
  int cells_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  longint cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  fenton_karma_cell_rates_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint rnd(longint n, longint d);
    return fdiv(2 * n + d, 2 * d);
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint tanh_lut(int i);
    longint t[25] = '{0, 16051, 30285, 41625, 49912, 55593, 59320, 61694, 63179,
      64096, 64659, 65003, 65212, 65339, 65417, 65464, 65492, 65509, 65520,
      65526, 65530, 65532, 65534, 65535, 65535};
    return t[i];
  endfunction

  function automatic longint tanh_q16(longint x);
    longint ax, idx, frac, t;
    ax = x < 0 ? -x : x;
    idx = ax >>> 22;
    frac = ax & ((64'sd1 << 22) - 1);
    if (idx >= 24) t = 65536;
    else t = tanh_lut(int'(idx)) +
             rnd((tanh_lut(int'(idx + 1)) - tanh_lut(int'(idx))) * frac, 64'sd1 << 22);
    return x < 0 ? -t : t;
  endfunction

  function automatic rates_t cell_rates(logic signed [15:0] mv, logic [15:0] gv,
                                        logic [15:0] gw);
    longint u, uc, jfi, jso, jsi, p, x, dv, vm, av, bv, aw, bw;
    bit below;
    rates_t r;
    uc = longint'(cell_cfg.fast_thr);
    u = rnd((longint'(mv) + 21504) * 655360, 219392);
    below = u <= uc;
    jfi = 0;
    if (u >= uc) begin
      p = rnd((65536 - u) * (u - uc), 65536);
      jfi = -rnd(longint'(gv) * longint'(cell_cfg.fast_rate) * p, 32768);
    end
    jso = below ? u * longint'(cell_cfg.open_rate) : longint'(cell_cfg.repol_rate) * 65536;
    x = longint'(cell_cfg.slow_k) * (u - longint'(cell_cfg.slow_thr));
    jsi = -rnd(longint'(cell_cfg.si_rate) * longint'(gw) * (65536 + tanh_q16(x)), 65536);
    dv = rnd(-(jfi + jso + jsi) * 857, 64'sd167772160);
    vm = (u >= longint'(cell_cfg.gate_thr)) ? longint'(GV1_MINUS) : longint'(GV2_MINUS);
    av = below ? -vm : -longint'(GV_PLUS);
    bv = below ? vm : 0;
    aw = below ? -longint'(GW_MINUS) : -longint'(GW_PLUS);
    bw = below ? longint'(GW_MINUS) : 0;
    r.dvm = 24'(clip24(dv));
    r.vrate = 24'(clip24(rnd(av * longint'(gv), 32768) + bv));
    r.wrate = 24'(clip24(rnd(aw * longint'(gw), 32768) + bw));
    r.vdecay = 19'(av);
    r.vdrive = 19'(bv);
    r.wdecay = 19'(aw);
    r.wdrive = 19'(bw);
    return r;
  endfunction

  // receiver stall pattern, changes mode every so often
  always @(posedge clk) begin
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ((cycles % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    rates_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = {dvm_dt, gate_v_rate, gate_w_rate, gate_v_decay, gate_v_drive,
             gate_w_decay, gate_w_drive};
      results_seen++;
      if (rates_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = rates_q.pop_front();
        if (got.dvm !== exp_r.dvm) begin
          $display("%0t dvm_dt exp %h got %h", $time, exp_r.dvm, got.dvm); errors++;
        end
        if (got.vrate !== exp_r.vrate) begin
          $display("%0t gate_v_rate exp %h got %h", $time, exp_r.vrate, got.vrate); errors++;
        end
        if (got.wrate !== exp_r.wrate) begin
          $display("%0t gate_w_rate exp %h got %h", $time, exp_r.wrate, got.wrate); errors++;
        end
        if (got.vdecay !== exp_r.vdecay) begin
          $display("%0t gate_v_decay exp %h got %h", $time, exp_r.vdecay, got.vdecay);
          errors++;
        end
        if (got.vdrive !== exp_r.vdrive) begin
          $display("%0t gate_v_drive exp %h got %h", $time, exp_r.vdrive, got.vdrive);
          errors++;
        end
        if (got.wdecay !== exp_r.wdecay) begin
          $display("%0t gate_w_decay exp %h got %h", $time, exp_r.wdecay, got.wdecay);
          errors++;
        end
        if (got.wdrive !== exp_r.wdrive) begin
          $display("%0t gate_w_drive exp %h got %h", $time, exp_r.wdrive, got.wdrive);
          errors++;
        end
      end
    end
  end

  // valid drops only when a gap follows, so it is driven once per edge
  task automatic send_cell(logic [15:0] mv, logic [15:0] gv, logic [15:0] gw);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    membrane_mv <= mv;
    gate_v <= gv;
    gate_w <= gw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rates_q.push_back(cell_rates(mv, gv, gw));
    cells_sent++;
    burst_left--;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (rates_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [31:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_FAST_THR: cell_cfg.fast_thr = data[15:0];
      REG_GATE_THR: cell_cfg.gate_thr = data[15:0];
      REG_SLOW_THR: cell_cfg.slow_thr = data[15:0];
      REG_SLOW_K: cell_cfg.slow_k = data[15:0];
      REG_FAST_RATE: cell_cfg.fast_rate = data[17:0];
      REG_OPEN_RATE: cell_cfg.open_rate = data[17:0];
      REG_REPOL: cell_cfg.repol_rate = data[17:0];
      REG_SI_RATE: cell_cfg.si_rate = data[17:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_gate();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'd0;
      2: return 16'd32768;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] rand_mv();
    // mostly physiological range -84..1.94 mV, sometimes anything
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 22000)) - 21504);
  endfunction

  task automatic test_directed;
    logic [15:0] mvs[8] = '{16'h8000, 16'h7fff, 16'hac00, 16'h01b3, 16'h0000,
                            16'hb6a0, 16'hc1f0, 16'hffff};
    foreach (mvs[i]) begin
      send_cell(mvs[i], 16'd32768, 16'd32768);
      send_cell(mvs[i], 16'd0, 16'hffff);
    end
    send_cell(16'hd000, 16'hffff, 16'd0);
    send_cell(16'hf000, 16'h5555, 16'haaaa);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_cell(rand_mv(), rand_gate(), rand_gate());
    drain();
  endtask

  task automatic test_config_extremes;
    for (int r = 0; r < 8; r++) write_reg(r, 32'h0);
    write_reg(32'd9, 32'h1234);
    test_random(150);
    for (int r = 0; r < 8; r++) write_reg(r, 32'hffffffff);
    test_random(150);
  endtask

  task automatic test_config_random;
    repeat (4) begin
      write_reg(REG_FAST_THR, $urandom_range(0, 65535));
      write_reg(REG_GATE_THR, $urandom_range(0, 65535));
      write_reg(REG_SLOW_THR, $urandom_range(40000, 65535));
      write_reg(REG_SLOW_K, $urandom_range(0, 8000));
      write_reg(REG_FAST_RATE, $urandom_range(0, 262143));
      write_reg(REG_OPEN_RATE, $urandom_range(0, 262143));
      write_reg(REG_REPOL, $urandom_range(0, 262143));
      write_reg(REG_SI_RATE, $urandom_range(0, 262143));
      test_random(150);
    end
  endtask

  task automatic test_reset_values;
    write_reg(REG_FAST_THR, 8520);
    write_reg(REG_GATE_THR, 2621);
    write_reg(REG_SLOW_THR, 56426);
    write_reg(REG_SLOW_K, 2560);
    write_reg(REG_FAST_RATE, 114688);
    write_reg(REG_OPEN_RATE, 5243);
    write_reg(REG_REPOL, 1937);
    write_reg(REG_SI_RATE, 2260);
    test_random(350);
  endtask

  initial begin
    cell_cfg = '{16'd8520, 16'd2621, 16'd56426, 16'd2560, 18'd114688, 18'd5243,
                 18'd1937, 18'd2260};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_config_extremes();
    test_config_random();
    test_reset_values();
    $display("sent %0d cells, checked %0d results, %0d register writes",
             cells_sent, results_seen, cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
